// ----- hdl/grid_local_peak_finder_core_assert.svh -----
// ----------------------------------------------------------------------------
// grid local peak finder assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef GRID_LOCAL_PEAK_FINDER_CORE_ASSERT_SVH
`define GRID_LOCAL_PEAK_FINDER_CORE_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define GLPF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that holds in the cycle after its trigger
`define GLPF_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/glpf_pkg.sv -----
// ----------------------------------------------------------------------------
// glpf_pkg
// shared types and constants of the grid local peak finder
// ----------------------------------------------------------------------------
package glpf_pkg;

    localparam int MAX_COLS_DEF    = 128;
    localparam int MAX_ROWS_DEF    = 128;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int PEAK_POS_W = 7;
    localparam int CFG_FIELD_W = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [0:0] {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [PEAK_POS_W-1:0] row;
        logic [PEAK_POS_W-1:0] col;
        logic                  last;
    } peak_t;

endpackage

// ----- hdl/grid_local_peak_finder_core.sv -----
// ----------------------------------------------------------------------------
// grid_local_peak_finder_core
// four neighbour local maximum detector over a raster-streamed grid
//
// samples enter on the in channel (in_valid, in_stall, sample, pad) in raster
// order; after the last real row one row of pad transactions closes the grid.
// a cell is reported on the out channel (peak_row, peak_col, final_cell) when
// it is >= its four neighbours above, below, left and right, cells outside the grid counting as zero.
// the report is made when the sample below the cell is accepted; it passes
// through the line ram stage, which pushes straight into the output queue,
// before it shows on out_valid. one sample is taken every cycle while
// in_stall is low; the rate is set by the single read and write port of each
// line ram, with forwarding covering a write and a read of the same entry in
// the same cycle. when the receiver stalls, results collect in a two entry
// output queue and in_stall rises once no room is left for a new transaction
// beside the one in flight. grid size registers sit on the apb port at 0x0
// (rows) and 0x4 (cols); a write restarts the grid. reset sets a 1x1 grid
// and zeroes the position counters; the line rams need no clearing, every middle
// line entry is written in the first row, every upper one in the second, before use.
// ----------------------------------------------------------------------------
`include "grid_local_peak_finder_core_assert.svh"

module grid_local_peak_finder_core
    import glpf_pkg::*;
#(
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          pad,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [PEAK_POS_W-1:0]         peak_row,
    output logic [PEAK_POS_W-1:0]         peak_col,
    output logic                          final_cell,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int CN_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [ROW_W-1:0]       rows_reg;
    logic [CN_W-1:0]        cols_reg;
    logic                   cfg_wr;
    logic [CFG_FIELD_W-1:0] cfg_val;
    logic [ROW_W-1:0]       rows_clamped;
    logic [CN_W-1:0]        cols_clamped;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_val = pwdata[CFG_FIELD_W-1:0];

    always_comb
    begin
        if (cfg_val == '0)
        begin
            rows_clamped = ROW_W'(1);
            cols_clamped = CN_W'(1);
        end
        else
        begin
            rows_clamped = (32'(cfg_val) > 32'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : ROW_W'(cfg_val);
            cols_clamped = (32'(cfg_val) > 32'(MAX_COLS)) ? CN_W'(MAX_COLS) : CN_W'(cfg_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROW_W'(1);
            cols_reg <= CN_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_GRID_ROWS: rows_reg <= rows_clamped;
                REG_GRID_COLS: cols_reg <= cols_clamped;
                default:       rows_reg <= rows_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_GRID_ROWS: prdata = PDATA_W'(rows_reg);
            REG_GRID_COLS: prdata = PDATA_W'(cols_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // position counters and accept stage
    // ------------------------------------------------------------------------
    logic             acc;
    logic [COL_W-1:0] col_count_reg;
    logic [COL_W-1:0] col_count_next;
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;
    logic [CN_W-1:0]  col_inc;
    logic [COL_W-1:0] mid_rd_addr;
    logic [31:0]      row_wide;
    logic [31:0]      col_wide;
    logic             row_end;
    logic signed [SAMPLE_BITS-1:0] below_in;
    peak_t            info_in;

    assign acc         = in_valid && !in_stall;
    assign col_inc     = CN_W'(col_count_reg) + CN_W'(1);
    assign mid_rd_addr = COL_W'(col_inc);
    assign row_end     = (col_inc == cols_reg);
    assign row_wide    = 32'(row_count_reg) - 32'd1;
    assign col_wide    = 32'(col_count_reg);
    assign below_in    = (pad || (row_count_reg >= rows_reg)) ? '0 : sample;

    assign info_in.row  = row_wide[PEAK_POS_W-1:0];
    assign info_in.col  = col_wide[PEAK_POS_W-1:0];
    assign info_in.last = (row_count_reg == rows_reg) && row_end;

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (cfg_wr && (paddr[2] == REG_GRID_ROWS || paddr[2] == REG_GRID_COLS))
        begin
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (acc)
        begin
            if (row_end)
            begin
                col_count_next = '0;
                row_count_next = (row_count_reg == rows_reg) ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_next = mid_rd_addr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ------------------------------------------------------------------------
    // line ram stage
    // ------------------------------------------------------------------------
    logic                          s1_valid_reg;
    logic [COL_W-1:0]              s1_col_reg;
    logic                          s1_first_row_reg;
    logic                          s1_second_row_reg;
    logic                          s1_left_ok_reg;
    logic                          s1_right_ok_reg;
    logic signed [SAMPLE_BITS-1:0] s1_below_reg;
    logic                          s1_fwd_mid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_fwd_mid_data_reg;
    logic                          s1_fwd_up_reg;
    logic signed [SAMPLE_BITS-1:0] s1_fwd_up_data_reg;
    peak_t                         s1_info_reg;

    logic signed [SAMPLE_BITS-1:0] col0_reg;
    logic signed [SAMPLE_BITS-1:0] prev_right_reg;
    logic signed [SAMPLE_BITS-1:0] prev_centre_reg;

    logic [SAMPLE_BITS-1:0]        mid_q;
    logic [SAMPLE_BITS-1:0]        up_q;
    logic signed [SAMPLE_BITS-1:0] mid_rd;
    logic signed [SAMPLE_BITS-1:0] up_rd;
    logic signed [SAMPLE_BITS-1:0] centre;
    logic signed [SAMPLE_BITS-1:0] up_val;
    logic signed [SAMPLE_BITS-1:0] left_val;
    logic signed [SAMPLE_BITS-1:0] right_val;
    logic                          s1_peak;
    logic                          up_we;

    glpf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_COLS)
    ) u_middle_line (
        .clk     (clk),
        .we      (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (s1_below_reg),
        .rd_addr (mid_rd_addr),
        .rd_data (mid_q)
    );

    glpf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_COLS)
    ) u_upper_line (
        .clk     (clk),
        .we      (up_we),
        .wr_addr (s1_col_reg),
        .wr_data (centre),
        .rd_addr (col_count_reg),
        .rd_data (up_q)
    );

    // same-entry write and read in the same cycle take the write data instead
    assign mid_rd = s1_fwd_mid_reg ? s1_fwd_mid_data_reg : $signed(mid_q);
    assign up_rd  = s1_fwd_up_reg ? s1_fwd_up_data_reg : $signed(up_q);

    // the cell being decided was read one transaction earlier as its right neighbour, or in column 0 sits in col0_reg
    assign centre    = (s1_col_reg == '0) ? col0_reg : prev_right_reg;
    assign up_val    = s1_second_row_reg ? '0 : up_rd;
    assign left_val  = s1_left_ok_reg ? prev_centre_reg : '0;
    assign right_val = s1_right_ok_reg ? mid_rd : '0;
    assign up_we     = s1_valid_reg && !s1_first_row_reg;

    assign s1_peak = s1_valid_reg && !s1_first_row_reg
                  && (centre >= up_val) && (centre >= s1_below_reg)
                  && (centre >= left_val) && (centre >= right_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_col_reg          <= col_count_reg;
            s1_first_row_reg    <= (row_count_reg == '0);
            s1_second_row_reg   <= (row_count_reg == ROW_W'(1));
            s1_left_ok_reg      <= (col_count_reg != '0);
            s1_right_ok_reg     <= (col_inc < cols_reg);
            s1_below_reg        <= below_in;
            s1_fwd_mid_reg      <= s1_valid_reg && (s1_col_reg == mid_rd_addr);
            s1_fwd_mid_data_reg <= s1_below_reg;
            s1_fwd_up_reg       <= up_we && (s1_col_reg == col_count_reg);
            s1_fwd_up_data_reg  <= centre;
            s1_info_reg         <= info_in;
        end
        if (s1_valid_reg)
        begin
            prev_right_reg  <= mid_rd;
            prev_centre_reg <= centre;
            if (s1_col_reg == '0)
            begin
                col0_reg <= s1_below_reg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output queue
    // ------------------------------------------------------------------------
    logic       pop;
    logic [1:0] q_level;
    logic [2:0] in_flight;
    peak_t      head;

    glpf_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_peak),
        .push_data (s1_info_reg),
        .pop       (pop),
        .head      (head),
        .level     (q_level)
    );

    assign out_valid  = (q_level != 2'd0);
    assign pop        = out_valid && !out_stall;
    assign peak_row   = head.row;
    assign peak_col   = head.col;
    assign final_cell = head.last;

    // room must remain for the transaction in the ram stage and a new one
    assign in_flight = 3'(q_level) + 3'(s1_valid_reg) - 3'(pop);
    assign in_stall  = (in_flight > 3'd1);

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `GLPF_ASSERT_ALWAYS(a_queue_no_overflow, !(s1_peak && q_level == 2'd2 && !pop),
        "result queue overflow")
    `GLPF_ASSERT_NEXT(a_peak_reaches_output, s1_peak, out_valid,
        "detected peak not presented on output")
    `GLPF_ASSERT_NEXT(a_accept_enters_stage, acc, s1_valid_reg,
        "accepted transaction missing from ram stage")
    `GLPF_ASSERT_ALWAYS(a_col_in_grid, CN_W'(col_count_reg) < cols_reg,
        "column counter beyond grid width")
    `GLPF_ASSERT_ALWAYS(a_row_in_grid, row_count_reg <= rows_reg,
        "row counter beyond pad row")

endmodule

// ----- hdl/glpf_ram.sv -----
// ----------------------------------------------------------------------------
// glpf_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module glpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/glpf_out_q.sv -----
// ----------------------------------------------------------------------------
// glpf_out_q
// two entry result queue: output register plus skid entry
// ----------------------------------------------------------------------------
module glpf_out_q
    import glpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  peak_t      push_data,
    input  logic       pop,
    output peak_t      head,
    output logic [1:0] level
);

    peak_t      q0_reg;
    peak_t      q1_reg;
    logic [1:0] level_reg;
    logic [1:0] level_next;

    always_comb
    begin
        level_next = level_reg;
        case ({push, pop})
            2'b10:   level_next = level_reg + 2'd1;
            2'b01:   level_next = level_reg - 2'd1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            // head leaves: skid moves up, or the new transaction fills in
            if (level_reg == 2'd2)
            begin
                q0_reg <= q1_reg;
                if (push)
                begin
                    q1_reg <= push_data;
                end
            end
            else if (push)
            begin
                q0_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (level_reg == 2'd0)
            begin
                q0_reg <= push_data;
            end
            else
            begin
                q1_reg <= push_data;
            end
        end
    end

    assign head  = q0_reg;
    assign level = level_reg;

endmodule
